/* rtl/dsr_pkg.sv */
`default_nettype none

package dsr_pkg;

  localparam int unsigned SETS_DEFAULT          = 2048;
  localparam int unsigned WAYS_DEFAULT          = 16;
  localparam int unsigned SELECTOR_BITS_DEFAULT = 10;
  localparam int unsigned LEADER_SETS_DEFAULT   = 32;

  localparam int unsigned SET_IN_BITS = 11;
  localparam int unsigned WAY_IN_BITS = 4;
  localparam int unsigned ADDR_BITS   = 64;
  localparam int unsigned PC_BITS     = 5;
  localparam int unsigned STREAM_BITS = 3;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // register index as decoded from the word address bit
  localparam logic REG_STREAM_THRESHOLD = 1'b0;

  localparam logic [1:0] DEAD_MAX   = 2'd3;
  localparam logic [1:0] RRPV_MAX   = 2'd3;
  localparam logic [1:0] RRPV_LONG  = 2'd2;
  localparam logic [1:0] RRPV_NEAR  = 2'd0;

  localparam logic signed [STREAM_BITS-1:0] STREAM_MAX       = 3'sd3;
  localparam logic signed [STREAM_BITS-1:0] STREAM_MIN       = -3'sd4;
  localparam logic signed [STREAM_BITS-1:0] STREAM_RESET     = 3'sd0;
  localparam logic signed [STREAM_BITS-1:0] THRESHOLD_RESET  = 3'sd2;

  localparam logic [ADDR_BITS-1:0] STRIDE_POS = 64'd64;
  localparam logic [ADDR_BITS-1:0] STRIDE_NEG = 64'hFFFF_FFFF_FFFF_FFC0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_QDEAD,
    ST_QAGE,
    ST_UDELTA,
    ST_UAPPLY
  } state_t;

  // x mod m for a quotient below 16, by restoring compare-subtract
  function automatic logic [15:0] mod_small(input logic [15:0] x, input int unsigned m);
    logic [20:0] r;
    logic [20:0] d;
    r = 21'(x);
    for (int k = 3; k >= 0; k--) begin
      d = 21'(m) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/dsr_ram.sv */
`default_nettype none

module dsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/dead_stream_rrip_replacement.sv */
// Dead-block and streaming-aware RRIP replacement engine with SRRIP/BRRIP set
// dueling. Each set's replacement row (per-way dead score and RRPV, previous
// address, stream score) lives in one single-port RAM. After reset a clearing
// sweep writes the reset row into every set; no transaction is accepted
// during it, configuration writes are. Then one transaction is worked at a
// time: a victim query returns a way with dead score 3 when there is one,
// else it runs RRPV ageing rounds over the row, up to three; an update goes
// through RAM read, stride check, row adjust and write-back. A finished
// victim waits in the output register while the next transaction is
// accepted.
`default_nettype none

module dead_stream_rrip_replacement #(
  parameter int unsigned SETS          = dsr_pkg::SETS_DEFAULT,
  parameter int unsigned WAYS          = dsr_pkg::WAYS_DEFAULT,
  parameter int unsigned SELECTOR_BITS = dsr_pkg::SELECTOR_BITS_DEFAULT,
  parameter int unsigned LEADER_SETS   = dsr_pkg::LEADER_SETS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               command,
  input  wire logic [dsr_pkg::SET_IN_BITS-1:0]    set_index,
  input  wire logic [dsr_pkg::WAY_IN_BITS-1:0]    way,
  input  wire logic                               hit,
  input  wire logic [dsr_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [dsr_pkg::PC_BITS-1:0]        pc_low,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [dsr_pkg::WAY_IN_BITS-1:0]         victim_way,
  input  wire logic                               apb_psel,
  input  wire logic                               apb_penable,
  input  wire logic                               apb_pwrite,
  input  wire logic [dsr_pkg::APB_ADDR_BITS-1:0]  apb_paddr,
  input  wire logic [dsr_pkg::APB_DATA_BITS-1:0]  apb_pwdata,
  output logic [dsr_pkg::APB_DATA_BITS-1:0]       apb_prdata,
  output logic                                    apb_pready
);

  localparam int unsigned SW = $clog2(SETS);
  localparam int unsigned WW = $clog2(WAYS);
  localparam int unsigned AB = dsr_pkg::ADDR_BITS;
  localparam int unsigned SB = dsr_pkg::STREAM_BITS;
  localparam int unsigned RW = 4 * WAYS + AB + SB;
  localparam int unsigned RRPV_LSB   = 2 * WAYS;
  localparam int unsigned PREV_LSB   = 4 * WAYS;
  localparam int unsigned STREAM_LSB = 4 * WAYS + AB;
  localparam logic [16:0] LEAD_S_END = 17'(LEADER_SETS);
  localparam logic [16:0] LEAD_B_END = 17'(2 * LEADER_SETS);
  localparam logic [SELECTOR_BITS-1:0] PSEL_HALF = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
  localparam logic [SELECTOR_BITS-1:0] PSEL_MAX  = '1;
  localparam logic [SW-1:0] SET_LAST = SW'(SETS - 1);

  // configuration
  logic signed [SB-1:0] threshold;
  logic                 cfg_we;

  assign apb_pready = 1'b1;
  assign cfg_we = apb_psel && apb_penable && apb_pwrite && apb_pready &&
                  (apb_paddr[2] == dsr_pkg::REG_STREAM_THRESHOLD);

  always_comb begin
    apb_prdata = '0;
    if (apb_paddr[2] == dsr_pkg::REG_STREAM_THRESHOLD) begin
      apb_prdata = {{(dsr_pkg::APB_DATA_BITS - SB){1'b0}}, threshold};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= dsr_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= apb_pwdata[SB-1:0];
    end
  end

  // sequencer state
  dsr_pkg::state_t state, state_next;
  logic [SW-1:0]   clr_idx;
  logic [SELECTOR_BITS-1:0] psel, psel_next;

  // transaction registers
  logic            cmd_r;
  logic [SW-1:0]   set_r;
  logic [WW-1:0]   way_r;
  logic            hit_r;
  logic [AB-1:0]   paddr_r;
  logic [dsr_pkg::PC_BITS-1:0] pc_r;

  // working row
  logic [1:0]           dead      [WAYS];
  logic [1:0]           dead_next [WAYS];
  logic [1:0]           rrpv      [WAYS];
  logic [1:0]           rrpv_next [WAYS];
  logic [AB-1:0]        prev, prev_next;
  logic signed [SB-1:0] stream, stream_next;

  // RAM port
  logic            mem_we;
  logic [SW-1:0]   mem_addr;
  logic [RW-1:0]   mem_wdata;
  logic [RW-1:0]   mem_rdata;

  // input reduction
  logic [15:0]     set_mod;
  logic [15:0]     way_mod;
  logic            in_accept;

  assign set_mod   = dsr_pkg::mod_small(16'(set_index), SETS);
  assign way_mod   = dsr_pkg::mod_small(16'(way), WAYS);
  assign in_stall  = (state != dsr_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // searches over the row
  logic          any_dead3, any_rrpv3;
  logic [WW-1:0] first_dead3, first_rrpv3;

  always_comb begin
    any_dead3   = 1'b0;
    any_rrpv3   = 1'b0;
    first_dead3 = '0;
    first_rrpv3 = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (dead[i] == dsr_pkg::DEAD_MAX) begin
        any_dead3   = 1'b1;
        first_dead3 = WW'(i);
      end
      if (rrpv[i] == dsr_pkg::RRPV_MAX) begin
        any_rrpv3   = 1'b1;
        first_rrpv3 = WW'(i);
      end
    end
  end

  // stride check
  logic [AB-1:0] delta;
  logic          stride_hit;
  logic          stride_nz;

  assign delta      = paddr_r - prev;
  assign stride_hit = (delta == dsr_pkg::STRIDE_POS) || (delta == dsr_pkg::STRIDE_NEG);
  assign stride_nz  = (delta != '0);

  // insertion policy
  logic                        lead_s, lead_b, use_s, streaming;
  logic [dsr_pkg::PC_BITS-1:0] key;

  assign lead_s    = (17'(set_r) < LEAD_S_END);
  assign lead_b    = !lead_s && (17'(set_r) < LEAD_B_END);
  assign use_s     = lead_s || (!lead_b && !psel[SELECTOR_BITS-1]);
  assign streaming = (stream >= threshold);
  assign key       = pc_r ^ paddr_r[dsr_pkg::PC_BITS-1:0];

  // output register
  logic          out_free;
  logic          out_load;
  logic [WW-1:0] out_way;
  logic [4:0]    out_way_ext;

  assign out_free    = !out_valid || !out_stall;
  assign out_way_ext = 5'(out_way);

  always_comb begin
    state_next  = state;
    psel_next   = psel;
    dead_next   = dead;
    rrpv_next   = rrpv;
    prev_next   = prev;
    stream_next = stream;
    mem_we      = 1'b0;
    mem_addr    = set_r;
    out_load    = 1'b0;
    out_way     = first_dead3;

    unique case (state)
      dsr_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_idx;
        if (clr_idx == SET_LAST) begin
          state_next = dsr_pkg::ST_IDLE;
        end
      end
      dsr_pkg::ST_IDLE: begin
        mem_addr = set_mod[SW-1:0];
        if (in_accept) begin
          state_next = dsr_pkg::ST_LOAD;
        end
      end
      dsr_pkg::ST_LOAD: begin
        for (int i = 0; i < WAYS; i++) begin
          dead_next[i] = mem_rdata[2 * i +: 2];
          rrpv_next[i] = mem_rdata[RRPV_LSB + 2 * i +: 2];
        end
        prev_next   = mem_rdata[PREV_LSB +: AB];
        stream_next = mem_rdata[STREAM_LSB +: SB];
        state_next  = (cmd_r == dsr_pkg::CMD_UPDATE) ? dsr_pkg::ST_UDELTA
                                                     : dsr_pkg::ST_QDEAD;
      end
      dsr_pkg::ST_QDEAD: begin
        if (!any_dead3) begin
          state_next = dsr_pkg::ST_QAGE;
        end else if (out_free) begin
          out_load   = 1'b1;
          state_next = dsr_pkg::ST_IDLE;
        end
      end
      dsr_pkg::ST_QAGE: begin
        out_way = first_rrpv3;
        if (!any_rrpv3) begin
          for (int i = 0; i < WAYS; i++) begin
            rrpv_next[i] = rrpv[i] + 2'd1;
          end
        end else if (out_free) begin
          out_load   = 1'b1;
          mem_we     = 1'b1;
          state_next = dsr_pkg::ST_IDLE;
        end
      end
      dsr_pkg::ST_UDELTA: begin
        if (stride_hit) begin
          if (stream != dsr_pkg::STREAM_MAX) begin
            stream_next = stream + SB'(1);
          end
        end else if (stride_nz) begin
          if (stream != dsr_pkg::STREAM_MIN) begin
            stream_next = stream - SB'(1);
          end
        end
        prev_next  = paddr_r;
        state_next = dsr_pkg::ST_UAPPLY;
      end
      dsr_pkg::ST_UAPPLY: begin
        if (hit_r) begin
          if (dead[way_r] != 2'd0) begin
            dead_next[way_r] = dead[way_r] - 2'd1;
          end
          rrpv_next[way_r] = dsr_pkg::RRPV_NEAR;
        end else begin
          for (int i = 0; i < WAYS; i++) begin
            if (dead[i] != dsr_pkg::DEAD_MAX) begin
              dead_next[i] = dead[i] + 2'd1;
            end
          end
          dead_next[way_r] = 2'd0;
          if (streaming) begin
            rrpv_next[way_r] = (key[2:0] != 3'd0) ? dsr_pkg::RRPV_MAX : dsr_pkg::RRPV_LONG;
            if (lead_b && psel != PSEL_MAX) begin
              psel_next = psel + SELECTOR_BITS'(1);
            end
          end else if (use_s) begin
            rrpv_next[way_r] = dsr_pkg::RRPV_LONG;
            if (lead_s && psel != '0) begin
              psel_next = psel - SELECTOR_BITS'(1);
            end
          end else begin
            rrpv_next[way_r] = (key != '0) ? dsr_pkg::RRPV_LONG : dsr_pkg::RRPV_MAX;
            if (lead_b && psel != PSEL_MAX) begin
              psel_next = psel + SELECTOR_BITS'(1);
            end
          end
        end
        mem_we     = 1'b1;
        state_next = dsr_pkg::ST_IDLE;
      end
      default: begin
        state_next = dsr_pkg::ST_IDLE;
      end
    endcase
  end

  // write data: reset row during the sweep, else the adjusted row
  always_comb begin
    mem_wdata = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (state == dsr_pkg::ST_CLEAR) begin
        mem_wdata[RRPV_LSB + 2 * i +: 2] = dsr_pkg::RRPV_LONG;
      end else begin
        mem_wdata[2 * i +: 2]            = dead_next[i];
        mem_wdata[RRPV_LSB + 2 * i +: 2] = rrpv_next[i];
      end
    end
    if (state != dsr_pkg::ST_CLEAR) begin
      mem_wdata[PREV_LSB +: AB]   = prev_next;
      mem_wdata[STREAM_LSB +: SB] = stream_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dsr_pkg::ST_CLEAR;
      clr_idx   <= '0;
      psel      <= PSEL_HALF;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      psel  <= psel_next;
      if (state == dsr_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + SW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r   <= command;
      set_r   <= set_mod[SW-1:0];
      way_r   <= way_mod[WW-1:0];
      hit_r   <= hit;
      paddr_r <= paddr;
      pc_r    <= pc_low;
    end
    if (out_load) begin
      victim_way <= out_way_ext[3:0];
    end
    dead   <= dead_next;
    rrpv   <= rrpv_next;
    prev   <= prev_next;
    stream <= stream_next;
  end

  dsr_ram #(
    .WIDTH (RW),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == dsr_pkg::ST_CLEAR) |-> !out_valid)
    else $error("result presented during clearing sweep");

  a_write_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == dsr_pkg::ST_CLEAR || state == dsr_pkg::ST_QAGE ||
                state == dsr_pkg::ST_UAPPLY))
    else $error("row RAM written outside a finishing step");

  a_update_gives_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == dsr_pkg::CMD_UPDATE && !out_valid) |=> !out_valid)
    else $error("update transaction produced a result");

endmodule

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = dsr_pkg::SETS_DEFAULT;
  localparam int NWAYS = dsr_pkg::WAYS_DEFAULT;
  localparam int NLEAD = dsr_pkg::LEADER_SETS_DEFAULT;
  localparam int SELW  = dsr_pkg::SELECTOR_BITS_DEFAULT;
  localparam logic [SELW-1:0] SEL_HALF = SELW'(1 << (SELW - 1));
  localparam logic [SELW-1:0] SEL_TOP  = '1;
  localparam logic [dsr_pkg::APB_ADDR_BITS-1:0] THRESHOLD_ADDR = 3'd0;
  localparam logic [dsr_pkg::APB_ADDR_BITS-1:0] UNMAPPED_ADDR  = 3'd4;

  typedef struct {
    logic                            command;
    logic [dsr_pkg::SET_IN_BITS-1:0] set_index;
    logic [dsr_pkg::WAY_IN_BITS-1:0] way;
    logic                            hit;
    logic [dsr_pkg::ADDR_BITS-1:0]   paddr;
    logic [dsr_pkg::PC_BITS-1:0]     pc_low;
  } access_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                command = dsr_pkg::CMD_QUERY;
  logic [dsr_pkg::SET_IN_BITS-1:0]     set_index = '0;
  logic [dsr_pkg::WAY_IN_BITS-1:0]     way = '0;
  logic                                hit = 1'b0;
  logic [dsr_pkg::ADDR_BITS-1:0]       paddr = '0;
  logic [dsr_pkg::PC_BITS-1:0]         pc_low = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [dsr_pkg::WAY_IN_BITS-1:0]     victim_way;
  logic                                apb_psel = 1'b0;
  logic                                apb_penable = 1'b0;
  logic                                apb_pwrite = 1'b0;
  logic [dsr_pkg::APB_ADDR_BITS-1:0]   apb_paddr = '0;
  logic [dsr_pkg::APB_DATA_BITS-1:0]   apb_pwdata = '0;
  logic [dsr_pkg::APB_DATA_BITS-1:0]   apb_prdata;
  logic                                apb_pready;

  dead_stream_rrip_replacement dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .set_index(set_index), .way(way), .hit(hit),
    .paddr(paddr), .pc_low(pc_low),
    .out_valid(out_valid), .out_stall(out_stall), .victim_way(victim_way),
    .apb_psel(apb_psel), .apb_penable(apb_penable), .apb_pwrite(apb_pwrite),
    .apb_paddr(apb_paddr), .apb_pwdata(apb_pwdata), .apb_prdata(apb_prdata),
    .apb_pready(apb_pready)
  );

  always #5 clk = ~clk;

  // shadow replacement state
  logic [1:0]                             dead_lvl   [NSETS][NWAYS];
  logic [1:0]                             rrpv       [NSETS][NWAYS];
  logic [dsr_pkg::ADDR_BITS-1:0]          last_paddr [NSETS];
  logic signed [dsr_pkg::STREAM_BITS-1:0] strm_lvl   [NSETS];
  logic [SELW-1:0]                        duel_sel;
  logic signed [dsr_pkg::STREAM_BITS-1:0] stream_thr;

  logic [dsr_pkg::WAY_IN_BITS-1:0] victims_due [$];
  access_t                pending [$];
  access_t                cur;
  int                     queued_count = 0;
  int                     in_accepted = 0;
  int                     errors = 0;
  bit                     no_idle = 1'b0;
  int                     src_idle = 0;
  int                     sink_hold = 0;
  bit                     long_done = 1'b0;

  int unsigned          hot_sets [10] = '{0, 1, 31, 32, 33, 63, 64, 100, 1000, 2047};
  logic [dsr_pkg::ADDR_BITS-1:0] stride_base [int];

  function automatic logic [dsr_pkg::WAY_IN_BITS-1:0] pick_eviction(input int s);
    logic [1:0] top;
    int first;
    int v;
    for (int w = 0; w < NWAYS; w++)
      if (dead_lvl[s][w] == dsr_pkg::DEAD_MAX) return dsr_pkg::WAY_IN_BITS'(w);
    top = rrpv[s][0];
    first = 0;
    for (int w = 1; w < NWAYS; w++) begin
      if (rrpv[s][w] > top) begin
        top = rrpv[s][w];
        first = w;
      end
    end
    if (top < dsr_pkg::RRPV_MAX) begin
      for (int w = 0; w < NWAYS; w++) begin
        v = int'(rrpv[s][w]) + int'(dsr_pkg::RRPV_MAX - top);
        rrpv[s][w] = (v > 3) ? dsr_pkg::RRPV_MAX : 2'(v);
      end
    end
    return dsr_pkg::WAY_IN_BITS'(first);
  endfunction

  task automatic train_set(input access_t a);
    int s;
    int w;
    logic [dsr_pkg::ADDR_BITS-1:0] delta;
    logic [dsr_pkg::ADDR_BITS-1:0] key;
    bit lead_s;
    bit lead_b;
    bit use_s;
    s = int'(a.set_index) % NSETS;
    w = int'(a.way) % NWAYS;
    delta = a.paddr - last_paddr[s];
    if (delta == dsr_pkg::STRIDE_POS || delta == dsr_pkg::STRIDE_NEG) begin
      if (strm_lvl[s] < dsr_pkg::STREAM_MAX) strm_lvl[s] = strm_lvl[s] + 3'sd1;
    end else if (delta != '0) begin
      if (strm_lvl[s] > dsr_pkg::STREAM_MIN) strm_lvl[s] = strm_lvl[s] - 3'sd1;
    end
    last_paddr[s] = a.paddr;
    if (a.hit) begin
      if (dead_lvl[s][w] != 2'd0) dead_lvl[s][w] = dead_lvl[s][w] - 2'd1;
      rrpv[s][w] = dsr_pkg::RRPV_NEAR;
    end else begin
      for (int i = 0; i < NWAYS; i++)
        if (dead_lvl[s][i] < dsr_pkg::DEAD_MAX) dead_lvl[s][i] = dead_lvl[s][i] + 2'd1;
      dead_lvl[s][w] = 2'd0;
      lead_s = s < NLEAD;
      lead_b = !lead_s && s < 2 * NLEAD;
      use_s = lead_s ? 1'b1 : (lead_b ? 1'b0 : duel_sel < SEL_HALF);
      key = {{(dsr_pkg::ADDR_BITS-dsr_pkg::PC_BITS){1'b0}}, a.pc_low} ^ a.paddr;
      if (strm_lvl[s] >= stream_thr) begin
        rrpv[s][w] = (key[2:0] != 3'd0) ? dsr_pkg::RRPV_MAX : dsr_pkg::RRPV_LONG;
        if (lead_b && duel_sel < SEL_TOP) duel_sel = duel_sel + 1'b1;
      end else if (use_s) begin
        rrpv[s][w] = dsr_pkg::RRPV_LONG;
        if (lead_s && duel_sel > '0) duel_sel = duel_sel - 1'b1;
      end else begin
        rrpv[s][w] = (key[4:0] != 5'd0) ? dsr_pkg::RRPV_LONG : dsr_pkg::RRPV_MAX;
        if (lead_b && duel_sel < SEL_TOP) duel_sel = duel_sel + 1'b1;
      end
    end
  endtask

  task automatic advance_replacement(input access_t a);
    if (a.command == dsr_pkg::CMD_QUERY)
      victims_due.push_back(pick_eviction(int'(a.set_index) % NSETS));
    else
      train_set(a);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_replacement(cur);
        in_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (src_idle > 0) begin
          src_idle--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          command   <= cur.command;
          set_index <= cur.set_index;
          way       <= cur.way;
          hit       <= cur.hit;
          paddr     <= cur.paddr;
          pc_low    <= cur.pc_low;
          in_valid  <= 1'b1;
          if (!no_idle && $urandom_range(0, 9) == 0) src_idle = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (victims_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected victim transaction, actual victim_way=%0d",
                   $time, victim_way);
        end else if (victims_due[0] !== victim_way) begin
          errors++;
          $display("%0t: victim_way mismatch, expected %0d actual %0d",
                   $time, victims_due[0], victim_way);
          void'(victims_due.pop_front());
        end else begin
          void'(victims_due.pop_front());
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_stall <= 1'b1;
      end else if (!long_done && in_accepted >= 80) begin
        long_done = 1'b1;
        sink_hold = 299;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        sink_hold = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic access_t mk(input logic cmd, input int s, input int w, input logic h,
                                 input logic [dsr_pkg::ADDR_BITS-1:0] a, input int pc);
    access_t t;
    t.command = cmd;
    t.set_index = dsr_pkg::SET_IN_BITS'(s);
    t.way = dsr_pkg::WAY_IN_BITS'(w);
    t.hit = h;
    t.paddr = a;
    t.pc_low = dsr_pkg::PC_BITS'(pc);
    return t;
  endfunction

  function automatic access_t random_access(input bit favor_srrip);
    access_t a;
    int r;
    logic [dsr_pkg::ADDR_BITS-1:0] base;
    r = $urandom_range(0, 99);
    if (favor_srrip && r < 50)
      a.set_index = dsr_pkg::SET_IN_BITS'($urandom_range(0, NLEAD - 1));
    else if (r < 80) a.set_index = dsr_pkg::SET_IN_BITS'(hot_sets[$urandom_range(0, 9)]);
    else a.set_index = dsr_pkg::SET_IN_BITS'($urandom);
    a.command = ($urandom_range(0, 99) < 30) ? dsr_pkg::CMD_QUERY : dsr_pkg::CMD_UPDATE;
    a.way = dsr_pkg::WAY_IN_BITS'($urandom);
    a.hit = $urandom_range(0, 99) < 40;
    a.pc_low = dsr_pkg::PC_BITS'($urandom);
    base = stride_base.exists(int'(a.set_index)) ? stride_base[int'(a.set_index)] : '0;
    r = $urandom_range(0, 99);
    if (r < 45) a.paddr = base + dsr_pkg::STRIDE_POS;
    else if (r < 60) a.paddr = base + dsr_pkg::STRIDE_NEG;
    else if (r < 70) a.paddr = base;
    else a.paddr = {$urandom, $urandom};
    if (a.command == dsr_pkg::CMD_UPDATE) stride_base[int'(a.set_index)] = a.paddr;
    return a;
  endfunction

  task automatic queue_random(input int n, input bit favor_srrip);
    for (int i = 0; i < n; i++) begin
      pending.push_back(random_access(favor_srrip));
      queued_count++;
    end
  endtask

  task automatic drain();
    do @(negedge clk); while (in_accepted != queued_count || victims_due.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(input logic [dsr_pkg::APB_ADDR_BITS-1:0] addr,
                           input logic [dsr_pkg::APB_DATA_BITS-1:0] data);
    @(posedge clk);
    apb_psel    <= 1'b1;
    apb_penable <= 1'b0;
    apb_pwrite  <= 1'b1;
    apb_paddr   <= addr;
    apb_pwdata  <= data;
    @(posedge clk);
    apb_penable <= 1'b1;
    do @(posedge clk); while (!apb_pready);
    apb_psel    <= 1'b0;
    apb_penable <= 1'b0;
    apb_pwrite  <= 1'b0;
  endtask

  task automatic set_threshold(input logic signed [dsr_pkg::STREAM_BITS-1:0] thr);
    logic [dsr_pkg::APB_DATA_BITS-1:0] data;
    data = {$urandom} & ~32'h7 | {29'd0, thr};
    apb_write(THRESHOLD_ADDR, data);
    stream_thr = thr;
    @(negedge clk);
  endtask

  initial begin
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        dead_lvl[s][w] = 2'd0;
        rrpv[s][w] = dsr_pkg::RRPV_LONG;
      end
      last_paddr[s] = '0;
      strm_lvl[s] = dsr_pkg::STREAM_RESET;
    end
    duel_sel = SEL_HALF;
    stream_thr = dsr_pkg::THRESHOLD_RESET;

    pending.push_back(mk(dsr_pkg::CMD_QUERY,  0,    0,  1'b0, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 5,    15, 1'b0, 64'd64, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 5,    0,  1'b0, 64'd128, 31));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 5,    3,  1'b0, 64'd64, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 5,    3,  1'b1, 64'd64, 0));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  5,    0,  1'b0, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 5,    15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 31));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 7,    1,  1'b0, 64'h1000, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 7,    2,  1'b0, 64'h2000, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 7,    3,  1'b0, 64'h3000, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 7,    4,  1'b0, 64'h4000, 0));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  7,    0,  1'b0, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 7,    1,  1'b1, 64'h4040, 0));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  7,    0,  1'b0, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 40,   9,  1'b0, 64'h20, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 41,   9,  1'b0, 64'hFFFF_FFFF_FFFF_FFC0, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 2047, 0,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 31));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  2047, 0,  1'b0, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  40,   15, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 31));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  41,   0,  1'b0, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 63,   15, 1'b1, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_UPDATE, 64,   0,  1'b0, 64'h5555_AAAA_5555_AAAA, 21));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  64,   0,  1'b0, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  0,    0,  1'b0, 64'd0, 0));
    pending.push_back(mk(dsr_pkg::CMD_QUERY,  7,    0,  1'b0, 64'd0, 0));
    queued_count = pending.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    drain();
    set_threshold(dsr_pkg::STREAM_MAX);
    queue_random(120, 1'b0);

    drain();
    set_threshold(dsr_pkg::STREAM_MIN);
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_random(120, 1'b1);

    drain();
    set_threshold(3'sd0);
    queue_random(120, 1'b1);

    drain();
    set_threshold(-3'sd1);
    queue_random(80, 1'b0);
    do @(negedge clk); while (in_accepted < queued_count - 40);
    no_idle = 1'b1;
    queue_random(60, 1'b0);

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
